// ----- src/scl_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scl_pkg
// shared types and constants for the serial command line parser
// ----------------------------------------------------------------------------
package scl_pkg;

  localparam int unsigned LINE_LEN_DEF = 128;
  localparam int unsigned COUNT_W      = 8;
  localparam int unsigned VALUE_W      = 32;

  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_S     = 8'h53;
  localparam logic [7:0] CHAR_T     = 8'h54;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;

  localparam logic [COUNT_W-1:0] MIN_LINE = COUNT_W'(2);

  localparam logic [VALUE_W-1:0] MAG_CAP  = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam logic [VALUE_W-1:0] POS_MAX  = {1'b0, {(VALUE_W-1){1'b1}}};

  typedef enum logic [2:0] {
    PH_SKIP   = 3'b001,
    PH_DIGITS = 3'b010,
    PH_DONE   = 3'b100
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_SHORT   = 2'd1,
    ST_UNKNOWN = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0]         echo_byte;
    logic               line_end;
    status_t            status;
    logic [7:0]         command_letter;
    logic [VALUE_W-1:0] command_value;
  } scl_result_t;

endpackage

// ----- src/scl_parse.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scl_parse
// line state and running decimal accumulator, one word per step
// ----------------------------------------------------------------------------
module scl_parse import scl_pkg::*; #(
  parameter int unsigned LINE_LEN = LINE_LEN_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  logic [7:0]  rx_byte,
  output scl_result_t result
);

  logic [COUNT_W-1:0] byte_count, byte_count_next;
  logic [7:0]         first_byte, first_byte_next;
  phase_t             number_phase, number_phase_next;
  logic               negative_sign, negative_sign_next;
  logic [VALUE_W-1:0] magnitude, magnitude_next;

  logic               is_digit, is_space, line_end;
  logic [VALUE_W+2:0] prod;
  logic [VALUE_W-1:0] mag_digit;

  assign is_digit = rx_byte inside {[CHAR_ZERO:CHAR_NINE]};
  assign is_space = rx_byte inside {CHAR_SPACE, [CHAR_TAB:CHAR_CR]};

  assign prod = ({3'b000, magnitude} << 3) + ({3'b000, magnitude} << 1)
              + (VALUE_W+3)'(rx_byte - CHAR_ZERO);
  assign mag_digit = (prod > (VALUE_W+3)'(MAG_CAP)) ? MAG_CAP : prod[VALUE_W-1:0];

  always_comb begin
    first_byte_next    = first_byte;
    number_phase_next  = number_phase;
    negative_sign_next = negative_sign;
    magnitude_next     = magnitude;
    if (byte_count == '0) begin
      first_byte_next = rx_byte;
    end else begin
      case (number_phase)
        PH_SKIP: begin
          if (is_space) begin
            number_phase_next = PH_SKIP;
          end else if (rx_byte == CHAR_PLUS) begin
            number_phase_next = PH_DIGITS;
          end else if (rx_byte == CHAR_MINUS) begin
            negative_sign_next = 1'b1;
            number_phase_next  = PH_DIGITS;
          end else if (is_digit) begin
            magnitude_next    = mag_digit;
            number_phase_next = PH_DIGITS;
          end else begin
            number_phase_next = PH_DONE;
          end
        end
        PH_DIGITS: begin
          if (is_digit) begin
            magnitude_next = mag_digit;
          end else begin
            number_phase_next = PH_DONE;
          end
        end
        default: begin
          number_phase_next = number_phase;
        end
      endcase
    end
    byte_count_next = byte_count + COUNT_W'(1);
  end

  assign line_end = (rx_byte == CHAR_CR) || (rx_byte == CHAR_LF)
                 || (byte_count_next >= COUNT_W'(LINE_LEN));

  always_comb begin
    result                = '0;
    result.echo_byte      = rx_byte;
    result.line_end       = line_end;
    result.status         = ST_OK;
    if (line_end) begin
      if (byte_count_next < MIN_LINE) begin
        result.status = ST_SHORT;
      end else if (first_byte_next == CHAR_S || first_byte_next == CHAR_T) begin
        result.command_letter = first_byte_next;
        if (negative_sign_next) begin
          result.command_value = '0 - magnitude_next;
        end else if (magnitude_next >= MAG_CAP) begin
          result.command_value = POS_MAX;
        end else begin
          result.command_value = magnitude_next;
        end
      end else begin
        result.status         = ST_UNKNOWN;
        result.command_letter = first_byte_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count    <= '0;
      first_byte    <= '0;
      number_phase  <= PH_SKIP;
      negative_sign <= 1'b0;
      magnitude     <= '0;
    end else if (step) begin
      if (line_end) begin
        byte_count    <= '0;
        first_byte    <= '0;
        number_phase  <= PH_SKIP;
        negative_sign <= 1'b0;
        magnitude     <= '0;
      end else begin
        byte_count    <= byte_count_next;
        first_byte    <= first_byte_next;
        number_phase  <= number_phase_next;
        negative_sign <= negative_sign_next;
        magnitude     <= magnitude_next;
      end
    end
  end

endmodule

// ----- src/serial_command_line_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_command_line_parser
// echoes each word, parses a command letter and a decimal value per line
// an accepted word passes the input register, then the result register
// throughput: one word per cycle when not stalled, set by the accumulator update
// result register and input register advance together when not stalled
// reset: synchronous, clears line state and both valid flags
// ----------------------------------------------------------------------------
module serial_command_line_parser import scl_pkg::*; #(
  parameter int unsigned LINE_LEN = LINE_LEN_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               rx_valid,
  output logic               rx_stall,
  input  logic [7:0]         rx_byte,
  output logic               res_valid,
  input  logic               res_stall,
  output logic [7:0]         echo_byte,
  output logic               line_end,
  output logic [1:0]         status,
  output logic [7:0]         command_letter,
  output logic [VALUE_W-1:0] command_value
);

  logic        advance;
  logic        in_valid;
  logic [7:0]  in_byte;
  scl_result_t parse_result;
  scl_result_t result;

  assign advance  = !(res_valid && res_stall);
  assign rx_stall = !advance;

  scl_parse #(
    .LINE_LEN(LINE_LEN)
  ) u_parse (
    .clk     (clk),
    .rst     (rst),
    .step    (advance && in_valid),
    .rx_byte (in_byte),
    .result  (parse_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else if (advance) begin
      in_valid  <= rx_valid;
      res_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      in_byte <= rx_byte;
      if (in_valid) begin
        result <= parse_result;
      end
    end
  end

  assign echo_byte      = result.echo_byte;
  assign line_end       = result.line_end;
  assign status         = result.status;
  assign command_letter = result.command_letter;
  assign command_value  = result.command_value;

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for serial_command_line_parser. Every accepted word goes through
// a line parser kept in the testbench, which works out the echo, the line end,
// the status, the command letter and the saturated value. Results are checked
// in order, field by field. A short table of directed words runs first, then
// random lines: command lines with random spacing, signs, digits and tails,
// short lines, noise and lines that end by length. Both sides idle and stall
// at random in the first two phases, and not at all in the last.
// ----------------------------------------------------------------------------
module tb;
  import scl_pkg::*;

  localparam int unsigned LINE_LEN    = LINE_LEN_DEF;
  localparam int unsigned PHASE_WORDS = 550;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned N_DIR       = 25;

  typedef struct packed {
    logic [7:0]  b;
    logic        pinned;
    logic        line_end;
    status_t     st;
    logic [7:0]  letter;
    logic [31:0] value;
  } dir_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               rx_valid = 1'b0;
  logic               rx_stall;
  logic [7:0]         rx_byte = 8'h00;
  logic               res_valid;
  logic               res_stall = 1'b0;
  logic [7:0]         echo_byte;
  logic               line_end;
  logic [1:0]         status;
  logic [7:0]         command_letter;
  logic [VALUE_W-1:0] command_value;

  // typed expectation travels with the word it belongs to
  logic        pin_en = 1'b0;
  scl_result_t pin_word = '0;

  int unsigned snd_idle_pct = 33;
  int unsigned rcv_stall_pct = 55;
  int unsigned cycles = 0;
  int unsigned errors = 0;
  int unsigned n_words = 0;
  int unsigned n_ok = 0;
  int unsigned n_short = 0;
  int unsigned n_unknown = 0;
  int unsigned n_by_length = 0;

  // line state of the parser model
  logic [7:0]  cur_len = '0;
  logic [7:0]  cur_letter = '0;
  phase_t      num_phase = PH_SKIP;
  logic        num_neg = 1'b0;
  logic [31:0] num_mag = '0;

  scl_result_t parse_results[$];
  logic [7:0]  line_bytes[$];

  dir_row_t dir_rows [N_DIR] = '{
    '{CHAR_CR,    1'b1, 1'b1, ST_SHORT,   8'h00,  32'd0},
    '{CHAR_LF,    1'b1, 1'b1, ST_SHORT,   8'h00,  32'd0},
    '{CHAR_S,     1'b1, 1'b0, ST_OK,      8'h00,  32'd0},
    '{CHAR_CR,    1'b1, 1'b1, ST_OK,      CHAR_S, 32'd0},
    '{8'hFF,      1'b1, 1'b0, ST_OK,      8'h00,  32'd0},
    '{8'h00,      1'b0, 1'b0, ST_OK,      8'h00,  32'd0},
    '{CHAR_LF,    1'b1, 1'b1, ST_UNKNOWN, 8'hFF,  32'd0},
    '{CHAR_T,     1'b1, 1'b0, ST_OK,      8'h00,  32'd0},
    '{CHAR_SPACE, 1'b0, 1'b0, ST_OK,      8'h00,  32'd0},
    '{CHAR_MINUS, 1'b0, 1'b0, ST_OK,      8'h00,  32'd0},
    '{8'h34,      1'b0, 1'b0, ST_OK,      8'h00,  32'd0},
    '{8'h32,      1'b0, 1'b0, ST_OK,      8'h00,  32'd0},
    '{CHAR_CR,    1'b1, 1'b1, ST_OK,      CHAR_T, 32'hFFFF_FFD6},
    '{CHAR_S,     1'b1, 1'b0, ST_OK,      8'h00,  32'd0},
    '{CHAR_NINE,  1'b0, 1'b0, ST_OK,      8'h00,  32'd0},
    '{CHAR_NINE,  1'b0, 1'b0, ST_OK,      8'h00,  32'd0},
    '{CHAR_NINE,  1'b0, 1'b0, ST_OK,      8'h00,  32'd0},
    '{CHAR_NINE,  1'b0, 1'b0, ST_OK,      8'h00,  32'd0},
    '{CHAR_NINE,  1'b0, 1'b0, ST_OK,      8'h00,  32'd0},
    '{CHAR_NINE,  1'b0, 1'b0, ST_OK,      8'h00,  32'd0},
    '{CHAR_NINE,  1'b0, 1'b0, ST_OK,      8'h00,  32'd0},
    '{CHAR_NINE,  1'b0, 1'b0, ST_OK,      8'h00,  32'd0},
    '{CHAR_NINE,  1'b0, 1'b0, ST_OK,      8'h00,  32'd0},
    '{CHAR_NINE,  1'b0, 1'b0, ST_OK,      8'h00,  32'd0},
    '{CHAR_CR,    1'b1, 1'b1, ST_OK,      CHAR_S, POS_MAX}
  };

  serial_command_line_parser #(
    .LINE_LEN(LINE_LEN)
  ) uut (
    .clk(clk),
    .rst(rst),
    .rx_valid(rx_valid),
    .rx_stall(rx_stall),
    .rx_byte(rx_byte),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .echo_byte(echo_byte),
    .line_end(line_end),
    .status(status),
    .command_letter(command_letter),
    .command_value(command_value)
  );

  always #5 clk = ~clk;

  function automatic scl_result_t parse_word(input logic [7:0] c);
    scl_result_t r;
    logic        is_digit;
    logic        is_ws;
    logic [35:0] grown;
    r = '0;
    r.echo_byte = c;
    is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    is_ws = (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
    grown = 36'(num_mag) * 36'd10 + 36'(c - CHAR_ZERO);
    if (grown > 36'(MAG_CAP)) grown = 36'(MAG_CAP);
    if (cur_len == 0) begin
      cur_letter = c;
    end else if (num_phase == PH_SKIP) begin
      if (!is_ws) begin
        if (c == CHAR_PLUS) begin
          num_phase = PH_DIGITS;
        end else if (c == CHAR_MINUS) begin
          num_neg = 1'b1;
          num_phase = PH_DIGITS;
        end else if (is_digit) begin
          num_mag = grown[31:0];
          num_phase = PH_DIGITS;
        end else begin
          num_phase = PH_DONE;
        end
      end
    end else if (num_phase == PH_DIGITS) begin
      if (is_digit) num_mag = grown[31:0];
      else num_phase = PH_DONE;
    end
    cur_len = cur_len + 8'd1;
    if (c == CHAR_CR || c == CHAR_LF || cur_len >= LINE_LEN) begin
      r.line_end = 1'b1;
      if (c != CHAR_CR && c != CHAR_LF) n_by_length++;
      if (cur_len < MIN_LINE) begin
        r.status = ST_SHORT;
        n_short++;
      end else if (cur_letter == CHAR_S || cur_letter == CHAR_T) begin
        r.status = ST_OK;
        r.command_letter = cur_letter;
        if (num_neg) r.command_value = -num_mag;
        else r.command_value = (num_mag >= MAG_CAP) ? POS_MAX : num_mag;
        n_ok++;
      end else begin
        r.status = ST_UNKNOWN;
        r.command_letter = cur_letter;
        n_unknown++;
      end
      cur_len = '0;
      cur_letter = '0;
      num_phase = PH_SKIP;
      num_neg = 1'b0;
      num_mag = '0;
    end
    return r;
  endfunction

  function automatic logic [7:0] body_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(255)); while (b == CHAR_CR || b == CHAR_LF);
    return b;
  endfunction

  function automatic logic [7:0] line_stop();
    return $urandom_range(1) ? CHAR_CR : CHAR_LF;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      errors++;
    end
  endtask

  task automatic send_word(input logic [7:0] b, input logic pinned,
                           input scl_result_t pin);
    while ($urandom_range(99) < snd_idle_pct) begin
      rx_valid <= 1'b0;
      @(posedge clk);
    end
    rx_valid <= 1'b1;
    rx_byte  <= b;
    pin_en   <= pinned;
    pin_word <= pin;
    @(posedge clk);
    while (rx_stall) @(posedge clk);
  endtask

  task automatic make_line(input bit long_line);
    string       digits;
    logic [7:0]  lead;
    int unsigned n;
    line_bytes.delete();
    if (long_line) begin
      case ($urandom_range(2))
        0: lead = CHAR_S;
        1: lead = CHAR_T;
        default: lead = body_byte();
      endcase
      line_bytes.push_back(lead);
      if ($urandom_range(1)) line_bytes.push_back(CHAR_MINUS);
      n = $urandom_range(1);
      while (line_bytes.size() < LINE_LEN)
        line_bytes.push_back(n ? 8'(CHAR_ZERO + $urandom_range(9)) : body_byte());
      return;
    end
    case ($urandom_range(19))
      0: begin
        line_bytes.push_back(line_stop());
      end
      1, 2: begin
        // noise, may hold line ends of its own
        n = $urandom_range(20, 1);
        repeat (n) line_bytes.push_back(8'($urandom_range(255)));
        line_bytes.push_back(line_stop());
      end
      default: begin
        if ($urandom_range(9) < 8) lead = $urandom_range(1) ? CHAR_S : CHAR_T;
        else lead = body_byte();
        line_bytes.push_back(lead);
        n = $urandom_range(3);
        repeat (n) begin
          case ($urandom_range(3))
            0: line_bytes.push_back(CHAR_TAB);
            1: line_bytes.push_back(8'h0B);
            2: line_bytes.push_back(8'h0C);
            default: line_bytes.push_back(CHAR_SPACE);
          endcase
        end
        case ($urandom_range(2))
          1: line_bytes.push_back(CHAR_PLUS);
          2: line_bytes.push_back(CHAR_MINUS);
          default: ;
        endcase
        case ($urandom_range(5))
          0: digits = $sformatf("%0d", $urandom_range(9));
          1: digits = $sformatf("%0d", $urandom_range(99999));
          2: digits = $sformatf("%0d", $urandom);
          3: begin
            case ($urandom_range(3))
              0: digits = "2147483647";
              1: digits = "2147483648";
              2: digits = "2147483649";
              default: digits = "0002147483647";
            endcase
          end
          4: digits = $sformatf("%0d%0d", $urandom, $urandom_range(99999));
          default: digits = "";
        endcase
        for (int i = 0; i < digits.len(); i++) line_bytes.push_back(8'(digits[i]));
        if ($urandom_range(1)) begin
          n = $urandom_range(4, 1);
          repeat (n) line_bytes.push_back(body_byte());
        end
        line_bytes.push_back(line_stop());
      end
    endcase
  endtask

  always @(posedge clk) res_stall <= ($urandom_range(99) < rcv_stall_pct);

  always @(posedge clk) begin : watch
    scl_result_t want;
    if (!rst) begin
      if (rx_valid && !rx_stall) begin
        want = parse_word(rx_byte);
        if (pin_en) want = pin_word;
        parse_results.push_back(want);
        n_words++;
      end
      if (res_valid && !res_stall) begin
        if (parse_results.size() == 0) begin
          $error("result word with nothing pending: echo_byte %0h", echo_byte);
          errors++;
        end else begin
          want = parse_results.pop_front();
          check_field("echo_byte", 32'(want.echo_byte), 32'(echo_byte));
          check_field("line_end", 32'(want.line_end), 32'(line_end));
          check_field("status", 32'(want.status), 32'(status));
          check_field("command_letter", 32'(want.command_letter), 32'(command_letter));
          check_field("command_value", want.command_value, command_value);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("serial_command_line_parser regression: fail");
      $finish;
    end
  end

  initial begin
    int unsigned phase_words;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < N_DIR; i++)
      send_word(dir_rows[i].b, dir_rows[i].pinned,
                '{dir_rows[i].b, dir_rows[i].line_end, dir_rows[i].st,
                  dir_rows[i].letter, dir_rows[i].value});

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin snd_idle_pct = 33; rcv_stall_pct = 55; end
        1: begin snd_idle_pct = 55; rcv_stall_pct = 33; end
        default: begin snd_idle_pct = 0; rcv_stall_pct = 0; end
      endcase
      phase_words = 0;
      make_line(1'b1);
      while (phase_words < PHASE_WORDS) begin
        foreach (line_bytes[k]) send_word(line_bytes[k], 1'b0, '0);
        phase_words += line_bytes.size();
        make_line($urandom_range(39) == 0);
      end
    end
    rx_valid <= 1'b0;
    pin_en   <= 1'b0;

    while (parse_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("covered %0d words in %0d lines: %0d ok, %0d too short, %0d unknown",
             n_words, n_ok + n_short + n_unknown, n_ok, n_short, n_unknown);
    $display("%0d lines ended by length, idling on both sides in turn", n_by_length);
    if (errors == 0 && parse_results.size() == 0) begin
      $display("serial_command_line_parser regression: pass");
    end else begin
      $display("serial_command_line_parser regression: fail");
    end
    $finish;
  end

endmodule
